// File: src/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// Holds result codes, register indexes, CRC constants and bundle structs.
// No dependencies.
package bsfr_pkg;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned COUNT_W  = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_CRC    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_FORMAT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ABANDONED  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW_LEN = 3'd4;

	localparam logic [7:0] START_RESET  = 8'hB0;
	localparam logic [7:0] END_RESET    = 8'hB1;
	localparam logic [7:0] ESCAPE_RESET = 8'hB2;
	localparam logic [7:0] MASK_RESET   = 8'h04;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [COUNT_W-1:0] MIN_BODY = 10'd4;

	typedef struct packed {
		logic [7:0]         start_byte;
		logic [7:0]         end_byte;
		logic [7:0]         escape_byte;
		logic [7:0]         escape_mask;
		logic [COUNT_W-1:0] max_raw_length;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [7:0]         data;
		logic [7:0]         ftype;
		logic [7:0]         fsubtype;
		logic [COUNT_W-1:0] count;
		logic               last;
	} result_t;

endpackage

// File: src/byte_stuffed_frame_receiver_crc16_core.sv
// Byte-stuffed frame receiver with CRC-16 check: top level.
// Path from rx beat to result beat: input register, then result register.
// One rx byte per cycle when no result stalls; the byte CRC update sets the critical path.
// A stalled result holds the result register; the input register keeps accepting
// bytes until it holds one that yields a result. Reset (arst_n low) clears frame
// state and loads register defaults at once; no clearing pass.
module byte_stuffed_frame_receiver_crc16_core #(
	parameter int unsigned RAW_LIMIT = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              rx_valid,
	output logic                              rx_ready,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bsfr_pkg::KIND_W-1:0]       result_kind,
	output logic [7:0]                        data_byte,
	output logic [7:0]                        frame_type,
	output logic [7:0]                        frame_subtype,
	output logic [bsfr_pkg::COUNT_W-1:0]      payload_count,
	output logic                              frame_last
);

	bsfr_pkg::cfg_t cfg;

	bsfr_cfg_regs #(.RAW_LIMIT(RAW_LIMIT)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	logic                            inside_q;
	logic                            esc_q;
	logic [bsfr_pkg::COUNT_W-1:0]    raw_q;
	logic [bsfr_pkg::COUNT_W-1:0]    body_q;
	logic [15:0]                     crc_q;
	logic [7:0]                      held0_q;
	logic [7:0]                      held1_q;
	logic [7:0]                      type_q;
	logic [7:0]                      sub_q;

	logic                            inside_d;
	logic                            esc_d;
	logic [bsfr_pkg::COUNT_W-1:0]    raw_d;
	logic [bsfr_pkg::COUNT_W-1:0]    body_d;
	logic [15:0]                     crc_d;
	logic [7:0]                      held0_d;
	logic [7:0]                      held1_d;
	logic [7:0]                      type_d;
	logic [7:0]                      sub_d;

	logic                            has_res;
	bsfr_pkg::result_t               res_d;
	bsfr_pkg::result_t               res_q;
	logic                            out_valid_q;

	logic [15:0] crc_next;
	logic        out_free;
	logic        s1_adv;

	bsfr_crc16_byte u_crc (
		.crc_in  (crc_q),
		.data    (held0_q),
		.crc_out (crc_next)
	);

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && (!has_res || out_free);
	assign rx_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		logic [7:0]                   b;
		logic [bsfr_pkg::COUNT_W-1:0] released;
		logic [15:0]                  trailer;
		b        = byte_s1;
		released = (body_q >= bsfr_pkg::MIN_BODY) ? body_q - bsfr_pkg::MIN_BODY : '0;
		trailer  = {held1_q, held0_q};

		inside_d = inside_q;
		esc_d    = esc_q;
		raw_d    = raw_q;
		body_d   = body_q;
		crc_d    = crc_q;
		held0_d  = held0_q;
		held1_d  = held1_q;
		type_d   = type_q;
		sub_d    = sub_q;

		has_res        = 1'b0;
		res_d.kind     = bsfr_pkg::KIND_ABANDONED;
		res_d.data     = 8'h00;
		res_d.ftype    = type_q;
		res_d.fsubtype = sub_q;
		res_d.count    = released;
		res_d.last     = 1'b1;

		if (!inside_q) begin
			if (b == cfg.start_byte) begin
				inside_d = 1'b1;
				esc_d    = 1'b0;
				raw_d    = 10'd1;
				body_d   = '0;
				crc_d    = bsfr_pkg::CRC_INIT;
				type_d   = 8'h00;
				sub_d    = 8'h00;
			end
		end else if (b == cfg.end_byte) begin
			has_res = 1'b1;
			if (esc_q || body_q < bsfr_pkg::MIN_BODY) begin
				res_d.kind = bsfr_pkg::KIND_BAD_FORMAT;
			end else if (trailer == crc_q) begin
				res_d.kind = bsfr_pkg::KIND_GOOD;
			end else begin
				res_d.kind = bsfr_pkg::KIND_BAD_CRC;
			end
			inside_d = 1'b0;
			esc_d    = 1'b0;
		end else if (b == cfg.start_byte) begin
			// restart: report the old frame, open a fresh one
			has_res  = 1'b1;
			inside_d = 1'b1;
			esc_d    = 1'b0;
			raw_d    = 10'd1;
			body_d   = '0;
			crc_d    = bsfr_pkg::CRC_INIT;
			type_d   = 8'h00;
			sub_d    = 8'h00;
		end else if (raw_q >= cfg.max_raw_length) begin
			// overrun: drop the byte and the frame
			has_res  = 1'b1;
			inside_d = 1'b0;
			esc_d    = 1'b0;
		end else begin
			raw_d = raw_q + 10'd1;
			if (!esc_q && b == cfg.escape_byte) begin
				esc_d = 1'b1;
			end else begin
				if (esc_q) begin
					b = b ^ cfg.escape_mask;
				end
				esc_d  = 1'b0;
				body_d = body_q + 10'd1;
				if (body_q == 10'd0) begin
					held0_d = b;
					type_d  = b;
				end else if (body_q == 10'd1) begin
					held1_d = b;
					sub_d   = b;
				end else begin
					// shift the trailer delay line; the leaving byte enters the CRC
					held0_d = held1_q;
					held1_d = b;
					crc_d   = crc_next;
					if (body_q >= bsfr_pkg::MIN_BODY) begin
						has_res     = 1'b1;
						res_d.kind  = bsfr_pkg::KIND_PAYLOAD;
						res_d.data  = held0_q;
						res_d.count = body_q - 10'd3;
						res_d.last  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q    <= 1'b0;
			raw_q    <= '0;
			body_q   <= '0;
			crc_q    <= bsfr_pkg::CRC_INIT;
			type_q   <= 8'h00;
			sub_q    <= 8'h00;
		end else if (s1_adv) begin
			inside_q <= inside_d;
			esc_q    <= esc_d;
			raw_q    <= raw_d;
			body_q   <= body_d;
			crc_q    <= crc_d;
			type_q   <= type_d;
			sub_q    <= sub_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_adv && has_res) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = res_q.kind;
	assign data_byte     = res_q.data;
	assign frame_type    = res_q.ftype;
	assign frame_subtype = res_q.fsubtype;
	assign payload_count = res_q.count;
	assign frame_last    = res_q.last;

	a_last_marks_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.last == (res_q.kind != bsfr_pkg::KIND_PAYLOAD)))
		else $error("frame_last disagrees with result kind");

	a_payload_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.kind == bsfr_pkg::KIND_PAYLOAD) |-> (res_q.count != '0))
		else $error("payload beat with zero payload count");

	a_no_escape_outside: assert property (@(posedge clk) disable iff (!arst_n)
		!inside_q |-> !esc_q)
		else $error("escape pending outside a frame");

	a_body_within_raw: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> (body_q < raw_q))
		else $error("body count reached raw count");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && inside_q && byte_s1 == cfg.end_byte) |=> !inside_q)
		else $error("end byte did not close the frame");

endmodule

// File: src/bsfr_cfg_regs.sv
// Configuration register file of the frame receiver.
// Uses bsfr_pkg for register indexes, reset values and the cfg_t bundle.
module bsfr_cfg_regs #(
	parameter int unsigned RAW_LIMIT = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bsfr_pkg::cfg_t                     cfg
);

	bsfr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte     <= bsfr_pkg::START_RESET;
			cfg_q.end_byte       <= bsfr_pkg::END_RESET;
			cfg_q.escape_byte    <= bsfr_pkg::ESCAPE_RESET;
			cfg_q.escape_mask    <= bsfr_pkg::MASK_RESET;
			cfg_q.max_raw_length <= bsfr_pkg::COUNT_W'(RAW_LIMIT);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bsfr_pkg::REG_START_BYTE:  cfg_q.start_byte     <= cfg_data[7:0];
				bsfr_pkg::REG_END_BYTE:    cfg_q.end_byte       <= cfg_data[7:0];
				bsfr_pkg::REG_ESCAPE_BYTE: cfg_q.escape_byte    <= cfg_data[7:0];
				bsfr_pkg::REG_ESCAPE_MASK: cfg_q.escape_mask    <= cfg_data[7:0];
				bsfr_pkg::REG_MAX_RAW_LEN: cfg_q.max_raw_length <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/bsfr_crc16_byte.sv
// One-byte CRC-16/CCITT-FALSE update, MSB first, unrolled over eight bits.
// Uses bsfr_pkg for the generator polynomial.
module bsfr_crc16_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ bsfr_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
